[rtl/pds_pkg.sv]
package pds_pkg;

  // Search bounds
  localparam logic [2:0] M_FIRST = 3'd1;
  localparam logic [2:0] M_LAST  = 3'd5;
  localparam logic [1:0] L_FIRST = 2'd3;
  localparam logic [1:0] L_LAST  = 2'd0;
  localparam logic [6:0] N_FIRST = 7'd8;
  localparam logic [6:0] N_LAST  = 7'd127;

  // Frequency limits in kHz
  localparam logic [19:0] VCO_MIN_KHZ   = 20'd125000;
  localparam logic [18:0] VCO_MAX_RESET = 19'd265000;

  // Tolerance factors, parts per thousand
  localparam logic [31:0] TOL_LO = 32'd995;
  localparam logic [31:0] TOL_HI = 32'd1005;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic setup;
    logic step_n;
    logic next_l;
    logic next_m;
    logic mark_found;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic n_last;
    logic l_last;
    logic m_last;
    logic out_free;
  } dp_sts_t;

  // Per reference divider constants: vco = (n+1)*14318/(m+1) tracked as
  // quotient and remainder starting at n = 8 and stepping by 14318.
  typedef struct packed {
    logic [16:0] q0;    // quotient at n = 8
    logic [2:0]  r0;    // remainder at n = 8
    logic [12:0] cq;    // quotient of 14318 / d
    logic [2:0]  cr;    // remainder of 14318 / d
    logic [2:0]  d;     // divisor m + 1
  } mstep_t;

  function automatic mstep_t pds_mtab(input logic [2:0] m);
    mstep_t t;
    case (m)
      3'd1:    t = '{q0: 17'd64431, r0: 3'd0, cq: 13'd7159, cr: 3'd0, d: 3'd2};
      3'd2:    t = '{q0: 17'd42954, r0: 3'd0, cq: 13'd4772, cr: 3'd2, d: 3'd3};
      3'd3:    t = '{q0: 17'd32215, r0: 3'd2, cq: 13'd3579, cr: 3'd2, d: 3'd4};
      3'd4:    t = '{q0: 17'd25772, r0: 3'd2, cq: 13'd2863, cr: 3'd3, d: 3'd5};
      3'd5:    t = '{q0: 17'd21477, r0: 3'd0, cq: 13'd2386, cr: 3'd2, d: 3'd6};
      default: t = '{q0: 17'd64431, r0: 3'd0, cq: 13'd7159, cr: 3'd0, d: 3'd2};
    endcase
    return t;
  endfunction

endpackage

[rtl/pds_ctrl.sv]
module pds_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pds_pkg::dp_sts_t sts,
  output pds_pkg::dp_cmd_t cmd
);
  import pds_pkg::*;

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        // hold off requests while reset is held
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.start = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.mark_found = 1'b1;
          state_nxt      = ST_FINISH;
        end else if (!sts.n_last) begin
          cmd.step_n = 1'b1;
        end else if (!sts.l_last) begin
          cmd.next_l = 1'b1;
          state_nxt  = ST_SETUP;
        end else if (!sts.m_last) begin
          cmd.next_m = 1'b1;
          state_nxt  = ST_SETUP;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/pds_datapath.sv]
module pds_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [17:0]      in_target_clock_khz,
  input  logic             cfg_we,
  input  logic [18:0]      cfg_vco_max_khz,
  input  pds_pkg::dp_cmd_t cmd,
  output pds_pkg::dp_sts_t sts,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_found,
  output logic [6:0]       out_feedback_n,
  output logic [2:0]       out_ref_div_m,
  output logic [1:0]       out_post_div_l,
  output logic [2:0]       out_filter_f
);
  import pds_pkg::*;

  logic [18:0] vco_max_r;
  logic [17:0] clk_r;
  logic [2:0]  m_r;
  logic [1:0]  l_r;
  logic [6:0]  n_r;
  logic [19:0] q_r, q_nxt;
  logic [2:0]  r_r, r_nxt;
  logic [29:0] v1k_r, v1k_nxt;
  logic [24:0] v34_r, v34_nxt;
  logic [31:0] lo_r, hi_r;
  logic        found_r;
  logic        out_valid_r;
  logic        out_found_r;
  logic [6:0]  out_n_r;
  logic [2:0]  out_m_r;
  logic [1:0]  out_l_r;
  logic [2:0]  out_f_r;

  mstep_t      tab;
  logic [20:0] goal;
  logic [3:0]  rsum;
  logic        carry;
  logic [2:0]  filt;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vco_max_r <= VCO_MAX_RESET;
    end else if (cfg_we) begin
      vco_max_r <= cfg_vco_max_khz;
    end
  end

  // Step the vco quotient, remainder and scaled copies by one n
  always_comb begin
    tab     = pds_mtab(m_r);
    goal    = 21'(clk_r) << l_r;
    rsum    = 4'(r_r) + 4'(tab.cr);
    carry   = (rsum >= 4'(tab.d));
    r_nxt   = carry ? 3'(rsum - 4'(tab.d)) : 3'(rsum);
    q_nxt   = q_r + 20'(tab.cq) + 20'(carry);
    v1k_nxt = v1k_r + 30'(tab.cq) * 30'd1000 + (carry ? 30'd1000 : 30'd0);
    v34_nxt = v34_r + 25'(tab.cq) * 25'd34 + (carry ? 25'd34 : 25'd0);
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      clk_r <= in_target_clock_khz;
      m_r   <= M_FIRST;
      l_r   <= L_FIRST;
    end else if (cmd.next_m) begin
      m_r <= m_r + 3'd1;
      l_r <= L_FIRST;
    end else if (cmd.next_l) begin
      l_r <= l_r - 2'd1;
    end

    if (cmd.setup) begin
      n_r   <= N_FIRST;
      q_r   <= 20'(tab.q0);
      r_r   <= tab.r0;
      v1k_r <= 30'(tab.q0) * 30'd1000;
      v34_r <= 25'(tab.q0) * 25'd34;
      lo_r  <= 32'(goal) * TOL_LO;
      hi_r  <= 32'(goal) * TOL_HI;
    end else if (cmd.step_n) begin
      n_r   <= n_r + 7'd1;
      q_r   <= q_nxt;
      r_r   <= r_nxt;
      v1k_r <= v1k_nxt;
      v34_r <= v34_nxt;
    end
  end

  // Found flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.start) begin
      found_r <= 1'b0;
    end else if (cmd.mark_found) begin
      found_r <= 1'b1;
    end
  end

  // Loop filter: count thresholds of 34*vco that the value stays below
  always_comb begin
    filt = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      if (32'(v34_r) < 32'(1000 * (13476 - 1000 * k))) begin
        filt = filt + 3'd1;
      end
    end
  end

  // Status
  always_comb begin
    sts.hit      = (q_r >= VCO_MIN_KHZ) && (q_r <= 20'(vco_max_r)) &&
                   (32'(v1k_r) + 32'd999 >= lo_r) && (32'(v1k_r) <= hi_r);
    sts.n_last   = (n_r == N_LAST);
    sts.l_last   = (l_r == L_LAST);
    sts.m_last   = (m_r == M_LAST);
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, zeros on a miss
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r <= found_r;
      out_n_r     <= found_r ? n_r  : 7'd0;
      out_m_r     <= found_r ? m_r  : 3'd0;
      out_l_r     <= found_r ? l_r  : 2'd0;
      out_f_r     <= found_r ? filt : 3'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_feedback_n = out_n_r;
  assign out_ref_div_m  = out_m_r;
  assign out_post_div_l = out_l_r;
  assign out_filter_f   = out_f_r;

endmodule

[rtl/pll_divider_search.sv]
// PLL divider search.
// Input channel: in_valid / in_stall with in_target_clock_khz, the wanted
// pixel clock. Each request yields exactly one result on the output channel
// (out_valid / out_stall): found plus n, m, l and the loop filter setting,
// all zero when no divider set fits.
// cfg_we writes cfg_vco_max_khz, the VCO ceiling; write it only while idle.
// One request is searched at a time. Each (m, l) pair has a setup step and
// then tries n from 8 to 127; candidates within a pair run one per cycle
// through the incremental VCO accumulators. A hit ends the search at once;
// a full miss tries every pair before it reports.
// The next request is taken in the cycle after the search has handed its
// result to the output register, even while that result still waits to be
// taken.
// When the receiver holds out_stall, the result stays put and a finished
// search waits for the output register to free.
// Synchronous reset clears the controller and output valid, holds in_stall
// high and restores the VCO ceiling to 265000 kHz.
module pll_divider_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [17:0] in_target_clock_khz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [6:0]  out_feedback_n,
  output logic [2:0]  out_ref_div_m,
  output logic [1:0]  out_post_div_l,
  output logic [2:0]  out_filter_f,
  input  logic        cfg_we,
  input  logic [18:0] cfg_vco_max_khz
);
  import pds_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pds_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_target_clock_khz (in_target_clock_khz),
    .cfg_we              (cfg_we),
    .cfg_vco_max_khz     (cfg_vco_max_khz),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_feedback_n      (out_feedback_n),
    .out_ref_div_m       (out_ref_div_m),
    .out_post_div_l      (out_post_div_l),
    .out_filter_f        (out_filter_f)
  );

endmodule

[rtl/pds_checker.sv]
module pds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [6:0]  out_feedback_n,
  input logic [2:0]  out_ref_div_m,
  input logic [1:0]  out_post_div_l,
  input logic [2:0]  out_filter_f
);

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
      $stable(out_feedback_n) && $stable(out_ref_div_m) &&
      $stable(out_post_div_l) && $stable(out_filter_f))
    else $error("stalled result changed");

  // A miss reports all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_feedback_n == 7'd0 && out_ref_div_m == 3'd0 &&
      out_post_div_l == 2'd0 && out_filter_f == 3'd0)
    else $error("miss with nonzero fields");

  // A hit reports dividers within the search range
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_ref_div_m >= 3'd1 && out_ref_div_m <= 3'd5 &&
      out_feedback_n >= 7'd8)
    else $error("hit with divider out of range");

  // The block is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken during a search");

endmodule

bind pll_divider_search pds_checker u_pds_checker (.*);

[sim/pll_divider_search_checker.sv]
`timescale 1ns / 100ps

module pll_divider_search_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [17:0] in_target_clock_khz,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_found,
  input  logic [6:0]  out_feedback_n,
  input  logic [2:0]  out_ref_div_m,
  input  logic [1:0]  out_post_div_l,
  input  logic [2:0]  out_filter_f,
  input  logic        cfg_we,
  input  logic [18:0] cfg_vco_max_khz,
  output int          mismatch_count,
  output int          results_pending
);

  localparam logic [63:0] REF_KHZ       = 64'd14318;
  localparam logic [63:0] VCO_FLOOR_KHZ = 64'd125000;
  localparam logic [18:0] CEILING_RESET = 19'd265000;
  localparam logic [63:0] TOL_BELOW     = 64'd995;
  localparam logic [63:0] TOL_ABOVE     = 64'd1005;
  localparam logic [63:0] FILTER_BASE   = 64'd13475;
  localparam logic [63:0] FILTER_SLOPE  = 64'd34;
  localparam logic [63:0] PER_MILLE     = 64'd1000;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic       found;
    logic [6:0] n;
    logic [2:0] m;
    logic [1:0] l;
    logic [2:0] f;
  } divider_set_t;

  logic [18:0]  vco_ceiling;
  divider_set_t divider_q[$];

  // Loop filter: step down from the base by the scaled VCO, clamp to 0..7
  function automatic logic [2:0] loop_filter(input logic [63:0] vco);
    logic [63:0] drop;
    logic [63:0] setting;
    drop = (FILTER_SLOPE * vco) / PER_MILLE;
    if (drop > FILTER_BASE) return 3'd0;
    setting = (FILTER_BASE - drop) / PER_MILLE;
    return (setting > 64'd7) ? 3'd7 : setting[2:0];
  endfunction

  // Walk m up, l down, n up; report the first VCO inside both windows
  function automatic divider_set_t search_dividers(input logic [17:0] target_khz,
                                                   input logic [18:0] ceiling);
    divider_set_t hit;
    logic [63:0]  goal;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  vco;
    hit = '0;
    for (int m = 1; m <= 5; m++) begin
      for (int l = 3; l >= 0; l--) begin
        goal = {46'd0, target_khz} << l;
        lo = (TOL_BELOW * goal) / PER_MILLE;
        hi = (TOL_ABOVE * goal) / PER_MILLE;
        for (int n = 8; n <= 127; n++) begin
          vco = (64'(n + 1) * REF_KHZ) / 64'(m + 1);
          if (vco >= VCO_FLOOR_KHZ && vco <= {45'd0, ceiling} &&
              vco >= lo && vco <= hi) begin
            hit.found = 1'b1;
            hit.n = 7'(n);
            hit.m = 3'(m);
            hit.l = 2'(l);
            hit.f = loop_filter(vco);
            return hit;
          end
        end
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    divider_set_t want;
    divider_set_t got;
    if (!rst_n) begin
      vco_ceiling = CEILING_RESET;
      divider_q.delete();
      mismatch_count = 0;
    end else begin
      // predict each accepted request with the ceiling in force
      if (in_valid && !in_stall)
        divider_q.push_back(search_dividers(in_target_clock_khz, vco_ceiling));
      if (cfg_we)
        vco_ceiling = cfg_vco_max_khz;
      // compare each delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{found: out_found, n: out_feedback_n, m: out_ref_div_m,
                l: out_post_div_l, f: out_filter_f};
        if (divider_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result: found=%0d n=%0d m=%0d l=%0d f=%0d",
                     $realtime, got.found, got.n, got.m, got.l, got.f);
        end else begin
          want = divider_q.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: divider mismatch", $realtime);
              $display("  wanted found=%0d n=%0d m=%0d l=%0d f=%0d",
                       want.found, want.n, want.m, want.l, want.f);
              $display("  got    found=%0d n=%0d m=%0d l=%0d f=%0d",
                       got.found, got.n, got.m, got.l, got.f);
            end
          end
        end
      end
    end
    results_pending = divider_q.size();
  end

endmodule

[sim/pll_divider_search_test.sv]
`timescale 1ns / 100ps

module pll_divider_search_test;

  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 100;
  localparam int IDLE_PERCENT     = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [17:0] in_target_clock_khz = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [6:0]  out_feedback_n;
  logic [2:0]  out_ref_div_m;
  logic [1:0]  out_post_div_l;
  logic [2:0]  out_filter_f;
  logic        cfg_we = 1'b0;
  logic [18:0] cfg_vco_max_khz = '0;

  logic        steady = 1'b0;
  int          hold_requests = 0;
  int          holds_granted = 0;
  int          quiet_cycles = 0;
  int          mismatch_count;
  int          results_pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pll_divider_search uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_target_clock_khz (in_target_clock_khz),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_feedback_n      (out_feedback_n),
    .out_ref_div_m       (out_ref_div_m),
    .out_post_div_l      (out_post_div_l),
    .out_filter_f        (out_filter_f),
    .cfg_we              (cfg_we),
    .cfg_vco_max_khz     (cfg_vco_max_khz)
  );

  pll_divider_search_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_target_clock_khz (in_target_clock_khz),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_feedback_n      (out_feedback_n),
    .out_ref_div_m       (out_ref_div_m),
    .out_post_div_l      (out_post_div_l),
    .out_filter_f        (out_filter_f),
    .cfg_we              (cfg_we),
    .cfg_vco_max_khz     (cfg_vco_max_khz),
    .mismatch_count      (mismatch_count),
    .results_pending     (results_pending)
  );

  // Mostly realistic pixel clocks, some anywhere, some low ones that mostly fail to fit
  function automatic logic [17:0] pick_target();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return 18'($urandom_range(15625, 200000));
    if (sel < 90) return 18'($urandom);
    return 18'($urandom_range(0, 15624));
  endfunction

  // Offer one request, maybe after an idle gap; return on its accepting edge
  task automatic send_request(input logic [17:0] target_khz);
    logic stalled;
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      in_target_clock_khz <= 18'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_clock_khz <= target_khz;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Hold the sender until every predicted result has been delivered
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  task automatic write_vco_ceiling(input logic [18:0] khz);
    drain_results();
    cfg_we <= 1'b1;
    cfg_vco_max_khz <= khz;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off per request from the sender
  initial begin
    forever begin
      @(posedge clk);
      if (holds_granted != hold_requests) begin
        holds_granted++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Watchdog: give up when no request, result or write moves for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset ceiling: field extremes, bit patterns, edges of the VCO floor
    send_request(18'd0);
    send_request(18'd262143);
    send_request(18'd1);
    send_request(18'd15624);
    send_request(18'd15625);
    send_request(18'd16108);
    send_request(18'd131072);
    send_request(18'd65536);
    send_request(18'd174762);
    send_request(18'd87381);
    send_request(18'd25175);
    send_request(18'd100000);
    send_request(18'd200000);
    send_request(18'd250000);
    repeat (50) send_request(pick_target());

    // high ceiling: VCO high enough to drive the filter numerator negative
    write_vco_ceiling(19'd400000);
    send_request(18'd99600);
    send_request(18'd199000);
    send_request(18'd262143);
    send_request(18'd50000);
    repeat (46) send_request(pick_target());

    // ceiling at the floor: almost nothing fits
    write_vco_ceiling(19'd125000);
    repeat (20) send_request(pick_target());

    // ceiling beyond its range, all bits set
    write_vco_ceiling(19'd524287);
    repeat (40) send_request(pick_target());

    // ceilings below the floor: nothing can fit
    write_vco_ceiling(19'd0);
    send_request(18'd262143);
    repeat (3) send_request(pick_target());
    write_vco_ceiling(19'd124999);
    repeat (3) send_request(pick_target());

    // back to the reset ceiling; back up the block with fast hits
    write_vco_ceiling(19'd265000);
    hold_requests <= hold_requests + 1;
    repeat (8) send_request(18'd16108);

    // stretch with no idling on either side
    steady <= 1'b1;
    repeat (30) send_request(pick_target());
    steady <= 1'b0;
    repeat (25) send_request(pick_target());

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
rtl/pds_pkg.sv
rtl/pds_ctrl.sv
rtl/pds_datapath.sv
rtl/pll_divider_search.sv
rtl/pds_checker.sv
sim/pll_divider_search_checker.sv
sim/pll_divider_search_test.sv
